// File: rtl/size_class_buffer_pool_core_macros.svh
// ----------------------------------------------------------------------------
// Size class buffer pool assertion macros
// Concurrent property shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef SIZE_CLASS_BUFFER_POOL_CORE_MACROS_SVH
`define SIZE_CLASS_BUFFER_POOL_CORE_MACROS_SVH

// same-cycle implication
`define SCBP_ASSERT_HOLDS(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SCBP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/scbp_pkg.sv
// ----------------------------------------------------------------------------
// Size class buffer pool package
// Widths, codes, word types and helpers shared by the pool modules.
// ----------------------------------------------------------------------------
package scbp_pkg;

  localparam int NUM_CLASSES = 4;
  localparam int NUM_BUFFERS = 64;
  localparam int CLS_W       = 2;
  localparam int ID_W        = 6;
  localparam int LINK_W      = 7;
  localparam int SIZE_W      = 32;
  localparam int COUNT_W     = 7;
  localparam int DATA_W      = 32;
  localparam int ADDR_W      = 5;
  localparam int REG_IDX_W   = 3;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [LINK_W-1:0]    LIST_EMPTY     = LINK_W'(NUM_BUFFERS);
  localparam logic [SIZE_W-1:0]    MIN_EFF_SIZE   = SIZE_W'(8);
  localparam logic [SIZE_W-1:0]    SIZE_RESET_LO  = SIZE_W'(64);
  localparam logic [COUNT_W-1:0]   COUNT_RESET    = COUNT_W'(16);
  localparam logic [REG_IDX_W-1:0] REG_SIZE_BASE  = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_COUNT_BASE = REG_IDX_W'(NUM_CLASSES);

  typedef enum logic [1:0] {
    REQ_LEASE   = 2'd0,
    REQ_RELEASE = 2'd1,
    REQ_REBUILD = 2'd2
  } req_type_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_UNAVAIL = 2'd1,
    ST_INVALID = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    OP_LEASE,
    OP_RELEASE,
    OP_REBUILD,
    OP_INVALID
  } op_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_POP,
    B_BUILD,
    B_FINISH
  } back_state_t;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [SIZE_W-1:0] request_size;
    logic [ID_W-1:0]   buffer_id;
    logic [SIZE_W-1:0] buffer_length;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ID_W-1:0]   granted_id;
    logic [CLS_W-1:0]  class_index;
    logic [SIZE_W-1:0] granted_length;
  } rsp_t;

  typedef struct packed {
    op_t              op;
    logic [CLS_W-1:0] cls;
    logic [ID_W-1:0]  id;
  } cmd_t;

  typedef logic [NUM_CLASSES-1:0][SIZE_W-1:0]  size_vec_t;
  typedef logic [NUM_CLASSES-1:0][COUNT_W-1:0] count_vec_t;

  function automatic logic [SIZE_W-1:0] size_reset(input int k);
    return SIZE_RESET_LO << (2 * k);
  endfunction

  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
    return (s < MIN_EFF_SIZE) ? MIN_EFF_SIZE : s;
  endfunction

endpackage

// File: rtl/scbp_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module scbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/scbp_front.sv
// ----------------------------------------------------------------------------
// Pool front end
// Accepts request words, finds the covering class and queues a command.
// ----------------------------------------------------------------------------
module scbp_front (
  input  logic              req_valid,
  output logic              req_stall,
  input  scbp_pkg::req_t    req_word,
  input  scbp_pkg::size_vec_t eff,
  input  logic              q_full,
  output logic              q_push,
  output scbp_pkg::cmd_t    q_cmd
);
  import scbp_pkg::*;

  logic [SIZE_W-1:0] value;
  logic              found;
  logic [CLS_W-1:0]  cls;

  assign req_stall = q_full;
  assign q_push    = req_valid && !q_full;
  assign value     = (req_word.req_type == REQ_RELEASE) ? req_word.buffer_length
                                                        : req_word.request_size;

  always_comb begin
    found = 1'b0;
    cls   = '0;
    for (int k = NUM_CLASSES - 1; k >= 0; k--) begin
      if (eff[k] >= value) begin
        found = 1'b1;
        cls   = CLS_W'(k);
      end
    end
  end

  always_comb begin
    q_cmd.cls = cls;
    q_cmd.id  = req_word.buffer_id;
    case (req_word.req_type)
      REQ_LEASE: begin
        q_cmd.op = found ? OP_LEASE : OP_INVALID;
      end
      REQ_RELEASE: begin
        q_cmd.op = (found && ({1'b0, req_word.buffer_id} < LIST_EMPTY)) ? OP_RELEASE
                                                                        : OP_INVALID;
      end
      REQ_REBUILD: begin
        q_cmd.op = OP_REBUILD;
      end
      default: begin
        q_cmd.op = OP_INVALID;
      end
    endcase
  end

endmodule

// File: rtl/scbp_queue.sv
// ----------------------------------------------------------------------------
// Command queue
// Short FIFO between the front end and the list engine.
// ----------------------------------------------------------------------------
module scbp_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  scbp_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output scbp_pkg::cmd_t head_cmd
);
  import scbp_pkg::*;

  cmd_t              entry [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QCNT_W-1:0] count;

  assign full      = (count == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head_cmd  = entry[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: rtl/scbp_back.sv
// ----------------------------------------------------------------------------
// Pool list engine
// Carries out lease, release and rebuild on the free lists, one at a time.
// ----------------------------------------------------------------------------
module scbp_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  scbp_pkg::cmd_t       q_cmd,
  output logic                 q_pop,
  input  scbp_pkg::size_vec_t  eff,
  input  scbp_pkg::count_vec_t counts,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output scbp_pkg::rsp_t       rsp_word
);
  import scbp_pkg::*;

  back_state_t       state, state_next;
  logic [LINK_W-1:0] head [NUM_CLASSES];
  logic [LINK_W-1:0] head_next [NUM_CLASSES];
  logic [CLS_W-1:0]  pend_cls, pend_cls_next;
  logic [ID_W-1:0]   pend_id, pend_id_next;
  rsp_t              res, res_next;
  logic [LINK_W-1:0] bld_n, bld_n_next;
  logic [CLS_W-1:0]  bld_k, bld_k_next;
  logic [COUNT_W-1:0] bld_c, bld_c_next;
  logic              rsp_valid_next;
  rsp_t              rsp_word_next;

  logic              found;
  logic [CLS_W-1:0]  sel;

  logic              ram_we;
  logic [ID_W-1:0]   ram_waddr;
  logic [LINK_W-1:0] ram_wdata;
  logic              ram_re;
  logic [ID_W-1:0]   ram_raddr;
  logic [LINK_W-1:0] ram_rdata;

  scbp_ram #(
    .WIDTH (LINK_W),
    .DEPTH (NUM_BUFFERS)
  ) u_link (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    found = 1'b0;
    sel   = '0;
    for (int k = NUM_CLASSES - 1; k >= 0; k--) begin
      if ((CLS_W'(k) >= q_cmd.cls) && (head[k] != LIST_EMPTY)) begin
        found = 1'b1;
        sel   = CLS_W'(k);
      end
    end
  end

  always_comb begin
    state_next     = state;
    head_next      = head;
    pend_cls_next  = pend_cls;
    pend_id_next   = pend_id;
    res_next       = res;
    bld_n_next     = bld_n;
    bld_k_next     = bld_k;
    bld_c_next     = bld_c;
    rsp_valid_next = rsp_valid && rsp_stall;
    rsp_word_next  = rsp_word;
    q_pop          = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = '0;
    ram_re         = 1'b0;
    ram_raddr      = '0;

    case (state)
      B_IDLE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          res_next = '0;
          case (q_cmd.op)
            OP_LEASE: begin
              if (found) begin
                ram_re        = 1'b1;
                ram_raddr     = head[sel][ID_W-1:0];
                pend_cls_next = sel;
                pend_id_next  = head[sel][ID_W-1:0];
                state_next    = B_POP;
              end else begin
                res_next.status = ST_UNAVAIL;
                state_next      = B_FINISH;
              end
            end
            OP_RELEASE: begin
              ram_we                = 1'b1;
              ram_waddr             = q_cmd.id;
              ram_wdata             = head[q_cmd.cls];
              head_next[q_cmd.cls]  = {1'b0, q_cmd.id};
              res_next.status       = ST_OK;
              res_next.class_index  = q_cmd.cls;
              state_next            = B_FINISH;
            end
            OP_REBUILD: begin
              for (int k = 0; k < NUM_CLASSES; k++) begin
                head_next[k] = LIST_EMPTY;
              end
              bld_n_next = '0;
              bld_k_next = '0;
              bld_c_next = '0;
              state_next = B_BUILD;
            end
            default: begin
              res_next.status = ST_INVALID;
              state_next      = B_FINISH;
            end
          endcase
        end
      end
      B_POP: begin
        head_next[pend_cls]     = ram_rdata;
        res_next.status         = ST_OK;
        res_next.granted_id     = pend_id;
        res_next.class_index    = pend_cls;
        res_next.granted_length = eff[pend_cls];
        state_next              = B_FINISH;
      end
      B_BUILD: begin
        if (bld_n == LIST_EMPTY) begin
          res_next.status = ST_OK;
          state_next      = B_FINISH;
        end else if (bld_c < counts[bld_k]) begin
          ram_we           = 1'b1;
          ram_waddr        = bld_n[ID_W-1:0];
          ram_wdata        = head[bld_k];
          head_next[bld_k] = bld_n;
          bld_n_next       = bld_n + 1'b1;
          bld_c_next       = bld_c + 1'b1;
        end else if (bld_k == CLS_W'(NUM_CLASSES - 1)) begin
          res_next.status = ST_OK;
          state_next      = B_FINISH;
        end else begin
          bld_k_next = bld_k + 1'b1;
          bld_c_next = '0;
        end
      end
      B_FINISH: begin
        if (!rsp_valid || !rsp_stall) begin
          rsp_valid_next = 1'b1;
          rsp_word_next  = res;
          state_next     = B_IDLE;
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      rsp_valid <= 1'b0;
      for (int k = 0; k < NUM_CLASSES; k++) begin
        head[k] <= LIST_EMPTY;
      end
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
      head      <= head_next;
    end
  end

  always_ff @(posedge clk) begin
    pend_cls <= pend_cls_next;
    pend_id  <= pend_id_next;
    res      <= res_next;
    bld_n    <= bld_n_next;
    bld_k    <= bld_k_next;
    bld_c    <= bld_c_next;
    rsp_word <= rsp_word_next;
  end

endmodule

// File: rtl/size_class_buffer_pool_core.sv
// A lease passes B_IDLE, B_POP and B_FINISH; release, invalid and unavailable pass B_IDLE and B_FINISH.
// The list engine takes a new command only once the last is done; a lease waits on the registered link RAM read.
// Rebuild places ids class by class in B_BUILD, at most NUM_BUFFERS ids, then passes to B_FINISH.
// A two-word command queue lets up to two requests be taken while one is in work.
// Reset (synchronous): all free lists empty, queue empty, size and count registers
// back to 64/256/1024/4096 and 16; link RAM contents are left as they are.
// ----------------------------------------------------------------------------
// Size class buffer pool
// Segregated free-list allocator with an APB-style configuration port.
// ----------------------------------------------------------------------------
module size_class_buffer_pool_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  scbp_pkg::req_t                req_word,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output scbp_pkg::rsp_t                rsp_word,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [scbp_pkg::ADDR_W-1:0]   paddr,
  input  logic [scbp_pkg::DATA_W-1:0]   pwdata,
  output logic [scbp_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import scbp_pkg::*;

  size_vec_t            size_reg;
  count_vec_t           count_reg;
  size_vec_t            eff;
  logic [REG_IDX_W-1:0] reg_idx;

  logic q_full;
  logic q_push;
  cmd_t q_in;
  logic q_pop;
  logic q_valid;
  cmd_t q_head;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_CLASSES; k++) begin
        size_reg[k]  <= size_reset(k);
        count_reg[k] <= COUNT_RESET;
      end
    end else if (psel && penable && pwrite) begin
      if (reg_idx < REG_COUNT_BASE) begin
        size_reg[reg_idx[CLS_W-1:0]] <= pwdata;
      end else begin
        count_reg[reg_idx[CLS_W-1:0]] <= pwdata[COUNT_W-1:0];
      end
    end
  end

  always_comb begin
    if (reg_idx < REG_COUNT_BASE) begin
      prdata = size_reg[reg_idx[CLS_W-1:0]];
    end else begin
      prdata = DATA_W'(count_reg[reg_idx[CLS_W-1:0]]);
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_CLASSES; k++) begin
      eff[k] = eff_size(size_reg[k]);
    end
  end

  scbp_front u_front (
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_word  (req_word),
    .eff       (eff),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_in)
  );

  scbp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_cmd  (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head_cmd  (q_head)
  );

  scbp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_cmd     (q_head),
    .q_pop     (q_pop),
    .eff       (eff),
    .counts    (count_reg),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_word  (rsp_word)
  );

endmodule

// File: rtl/scbp_checker.sv
// ----------------------------------------------------------------------------
// Pool port checker
// Watches the top-level ports of the pool over time.
// ----------------------------------------------------------------------------
`include "size_class_buffer_pool_core_macros.svh"

module scbp_checker (
  input logic           clk,
  input logic           rst,
  input logic           rsp_valid,
  input logic           rsp_stall,
  input scbp_pkg::rsp_t rsp_word,
  input logic           pready
);
  import scbp_pkg::*;

  `SCBP_ASSERT_HOLDS(a_pready_high, clk, rst, 1'b1, pready, "pready dropped")

  `SCBP_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_word), "stalled rsp word changed")

  `SCBP_ASSERT_HOLDS(a_fail_zero, clk, rst, rsp_valid && (rsp_word.status != ST_OK), (rsp_word.granted_id == '0) && (rsp_word.class_index == '0) && (rsp_word.granted_length == '0), "failed word carries data")

  `SCBP_ASSERT_HOLDS(a_grant_min, clk, rst, rsp_valid && (rsp_word.granted_length != '0), (rsp_word.status == ST_OK) && (rsp_word.granted_length >= MIN_EFF_SIZE), "grant below minimum size")

endmodule

bind size_class_buffer_pool_core scbp_checker u_scbp_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp_word  (rsp_word),
  .pready    (pready)
);
